FILE: src/modular_inverse_fermat_macros.svh
// Assertion macros for the checker file of the modular inverse block.
`ifndef MODULAR_INVERSE_FERMAT_MACROS_SVH
`define MODULAR_INVERSE_FERMAT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MIF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mif check failed: label");

// Next-cycle implication, disabled while reset is high.
`define MIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mif check failed: label");

// Next-cycle implication that is also checked across reset.
`define MIF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mif check failed: label");

`endif

FILE: src/mif_pkg.sv
`default_nettype none

package mif_pkg;

  // Modulus after reset, cut to the configured width at the top level.
  localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

  // Sequencer state encoding.
  localparam int STATE_W = 3;
  localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STATE_W-1:0] ST_RED  = 3'd1;
  localparam logic [STATE_W-1:0] ST_EXP  = 3'd2;
  localparam logic [STATE_W-1:0] ST_MUL  = 3'd3;
  localparam logic [STATE_W-1:0] ST_DONE = 3'd4;

endpackage

`default_nettype wire

FILE: src/mif_modadd.sv
`default_nettype none

module mif_modadd #(
  parameter int MOD_WIDTH = 31
) (
  input  logic [MOD_WIDTH-1:0] x,
  input  logic [MOD_WIDTH-1:0] y,
  input  logic                 cin,
  input  logic [MOD_WIDTH-1:0] m,
  output logic [MOD_WIDTH-1:0] sum_mod
);

  // Both operands are below m, so the sum is below 2m and one conditional
  // subtraction brings it back into range.
  logic [MOD_WIDTH:0]   sum;
  logic [MOD_WIDTH+1:0] diff;

  always_comb begin
    sum  = {1'b0, x} + {1'b0, y} + {{MOD_WIDTH{1'b0}}, cin};
    diff = {1'b0, sum} - {2'b00, m};
    if (diff[MOD_WIDTH+1]) begin
      sum_mod = sum[MOD_WIDTH-1:0];
    end else begin
      sum_mod = diff[MOD_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: src/modular_inverse_fermat.sv
// Modular inverse of an unsigned value by Fermat exponentiation.
//
// Input channel (s_axis_*): one item carries the value in s_axis_tdata. The
// block takes an item only while it is idle; s_axis_tready stays low for the
// whole computation. Output channel (m_axis_*): one item per input item, the
// inverse in m_axis_tdata. The modulus is written through modulus_wr_en and
// modulus_wr_data; the user must write it only while no item is in flight,
// as the block does not enforce this; it must be prime for the result to be a true inverse.
//
// Sequence: the value is first reduced, one bit a cycle. Each exponent bit
// then costs a pass through the exponent state, a squaring and, for a set
// bit, a multiply; a multiply on the shared modular adder adds the
// multiplicand into the accumulator for each set multiplier bit, doubles it
// for each multiplier bit and finishes once the multiplier is zero. A zero
// residue or a modulus below two ends early.
// Reset (rst, synchronous) returns the sequencer to idle, drops the output
// valid and loads the modulus 1000000007. A finished result sits in the
// output register until the receiver takes it; the next item may be
// accepted meanwhile, and only the hand-over of its own result waits.
`default_nettype none

module modular_inverse_fermat #(
  parameter int MOD_WIDTH = 31
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration: modulus register.
  input  logic                                 modulus_wr_en,
  input  logic [MOD_WIDTH-1:0]                 modulus_wr_data,
  // Input stream. tdata: value [MOD_WIDTH-1:0], zero fill above.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((MOD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // Output stream. tdata: inverse [MOD_WIDTH-1:0], zero fill above.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((MOD_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);

  import mif_pkg::*;

  localparam int DATA_W = ((MOD_WIDTH + 7) / 8) * 8;
  localparam int CNT_W  = $clog2(MOD_WIDTH);

  logic [STATE_W-1:0]   state;
  logic [MOD_WIDTH-1:0] modulus;

  // Datapath registers. acc doubles as the running remainder while the
  // value is reduced.
  logic [MOD_WIDTH-1:0] vsh;     // value, shifted out MSB first
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] ma;      // multiplicand, doubled each bit
  logic [MOD_WIDTH-1:0] mb;      // multiplier, shifted right each bit
  logic [MOD_WIDTH-1:0] base;
  logic [MOD_WIDTH-1:0] result;
  logic [MOD_WIDTH-1:0] expo;
  logic [CNT_W-1:0]     cnt;
  logic                 squaring;
  logic                 added;
  logic [MOD_WIDTH-1:0] out_data;
  logic                 out_valid;

  // Shared modular adder and its operand select.
  logic [MOD_WIDTH-1:0] u_x;
  logic [MOD_WIDTH-1:0] u_y;
  logic                 u_cin;
  logic [MOD_WIDTH-1:0] u_sum;

  always_comb begin
    u_x   = '0;
    u_y   = '0;
    u_cin = 1'b0;
    case (state)
      ST_RED: begin
        // remainder = 2 * remainder + next value bit, reduced
        u_x   = acc;
        u_y   = acc;
        u_cin = vsh[MOD_WIDTH-1];
      end
      ST_MUL: begin
        if (mb[0] && !added) begin
          u_x = acc;
          u_y = ma;
        end else begin
          u_x = ma;
          u_y = ma;
        end
      end
      default: begin
        u_x = '0;
      end
    endcase
  end

  mif_modadd #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_modadd (
    .x       (u_x),
    .y       (u_y),
    .cin     (u_cin),
    .m       (modulus),
    .sum_mod (u_sum)
  );

  // Modulus register.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET[MOD_WIDTH-1:0];
    end else if (modulus_wr_en) begin
      modulus <= modulus_wr_data;
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            vsh <= s_axis_tdata[MOD_WIDTH-1:0];
            acc <= '0;
            cnt <= CNT_W'(MOD_WIDTH - 1);
            if (modulus < MOD_WIDTH'(2)) begin
              result <= '0;
              state  <= ST_DONE;
            end else begin
              state <= ST_RED;
            end
          end
        end
        ST_RED: begin
          acc <= u_sum;
          vsh <= {vsh[MOD_WIDTH-2:0], 1'b0};
          if (cnt == '0) begin
            if (u_sum == '0) begin
              result <= '0;
              state  <= ST_DONE;
            end else begin
              base   <= u_sum;
              result <= MOD_WIDTH'(1);
              expo   <= modulus - MOD_WIDTH'(2);
              state  <= ST_EXP;
            end
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_EXP: begin
          acc   <= '0;
          added <= 1'b0;
          if (expo == '0) begin
            state <= ST_DONE;
          end else if (expo[0]) begin
            // result = result * base first, then the square.
            ma       <= result;
            mb       <= base;
            squaring <= 1'b0;
            state    <= ST_MUL;
          end else begin
            ma       <= base;
            mb       <= base;
            squaring <= 1'b1;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mb == '0) begin
            if (squaring) begin
              base  <= acc;
              expo  <= expo >> 1;
              state <= ST_EXP;
            end else begin
              result   <= acc;
              ma       <= base;
              mb       <= base;
              acc      <= '0;
              added    <= 1'b0;
              squaring <= 1'b1;
            end
          end else if (mb[0] && !added) begin
            acc   <= u_sum;
            added <= 1'b1;
          end else begin
            ma    <= u_sum;
            mb    <= mb >> 1;
            added <= 1'b0;
          end
        end
        ST_DONE: begin
          if (!out_valid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || m_axis_tready)) begin
      out_data <= result;
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'(out_data);

endmodule

`default_nettype wire

FILE: src/mif_checker.sv
`default_nettype none

`include "modular_inverse_fermat_macros.svh"

module mif_checker #(
  parameter int MOD_WIDTH = 31
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [((MOD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  // A held result keeps its data until the receiver takes it.
  `MIF_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // One item at a time: after an item is taken the block is busy.
  `MIF_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A new result only appears at the end of a computation.
  `MIF_ASSERT_NOW(a_result_from_busy, clk, rst, $rose(m_axis_tvalid), $past(!s_axis_tready))

  // Reset empties the output register.
  `MIF_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !m_axis_tvalid && s_axis_tready)

endmodule

bind modular_inverse_fermat mif_checker #(
  .MOD_WIDTH (MOD_WIDTH)
) u_mif_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
